// File: rtl/frame_window_apply_defines.svh
// Assertion macros used by frame_window_apply
`ifndef FRAME_WINDOW_APPLY_DEFINES_SVH
`define FRAME_WINDOW_APPLY_DEFINES_SVH
// implication, sampled on clk, held off during reset
`define FWA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define FWA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/fwa_pkg.sv
// ----------------------------------------------------------------------------
// fwa_pkg
// Shared constants and types for the frame window block.
// ----------------------------------------------------------------------------
package fwa_pkg;
  localparam int MAX_FRAME_DEF = 1024;
  localparam int MAX_PAD_DEF   = 63;
  localparam logic [17:0] ONE_Q17 = 18'd131072;

  typedef enum logic [2:0] {
    WIN_BLACKMAN = 3'd0,
    WIN_HAMMING  = 3'd1,
    WIN_HANN     = 3'd2,
    WIN_BARTLETT = 3'd3,
    WIN_TRAP     = 3'd4,
    WIN_RECT     = 3'd5
  } win_t;

  localparam logic [1:0] REG_ORDER = 2'd0;
  localparam logic [1:0] REG_PAD   = 2'd1;
  localparam logic [1:0] REG_WIN   = 2'd2;
  localparam logic [1:0] REG_GAIN  = 2'd3;

  function automatic logic [21:0] atan_lut(input logic [4:0] k);
    case (k)
      5'd0:  atan_lut = 22'd2097152;
      5'd1:  atan_lut = 22'd1238021;
      5'd2:  atan_lut = 22'd654136;
      5'd3:  atan_lut = 22'd332050;
      5'd4:  atan_lut = 22'd166669;
      5'd5:  atan_lut = 22'd83416;
      5'd6:  atan_lut = 22'd41718;
      5'd7:  atan_lut = 22'd20860;
      5'd8:  atan_lut = 22'd10430;
      5'd9:  atan_lut = 22'd5215;
      5'd10: atan_lut = 22'd2608;
      5'd11: atan_lut = 22'd1304;
      5'd12: atan_lut = 22'd652;
      5'd13: atan_lut = 22'd326;
      5'd14: atan_lut = 22'd163;
      5'd15: atan_lut = 22'd81;
      5'd16: atan_lut = 22'd41;
      5'd17: atan_lut = 22'd20;
      default: atan_lut = 22'd0;
    endcase
  endfunction
endpackage

// File: rtl/fwa_cordic.sv
// ----------------------------------------------------------------------------
// fwa_cordic
// Iterative CORDIC cosine of a 24-bit turn phase, signed Q.20, 18 steps.
// ----------------------------------------------------------------------------
module fwa_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [23:0]        phase,
  output logic               done,
  output logic signed [21:0] cos_out
);
  logic signed [22:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [1:0]  quad_r, quad_nxt;
  logic [4:0]  k_r, k_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic signed [22:0] dx, dy, at;

  always_comb begin
    dx = y_r >>> k_r;
    dy = x_r >>> k_r;
    at = $signed({1'b0, fwa_pkg::atan_lut(k_r)});
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; quad_nxt = quad_r;
    k_nxt = k_r; busy_nxt = busy_r; done_nxt = 1'b0;
    if (start) begin
      x_nxt = 23'sd636751; y_nxt = '0;
      z_nxt = $signed({1'b0, phase[21:0]});
      quad_nxt = phase[23:22]; k_nxt = '0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!z_r[22]) begin
        x_nxt = x_r - dx; y_nxt = y_r + dy; z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + dx; y_nxt = y_r - dy; z_nxt = z_r + at;
      end
      k_nxt = k_r + 5'd1;
      if (k_r == 5'd17) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; k_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; k_r <= k_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; quad_r <= quad_nxt;
  end

  always_comb begin
    case (quad_r)
      2'd0:    cos_out = x_r[21:0];
      2'd1:    cos_out = -y_r[21:0];
      2'd2:    cos_out = -x_r[21:0];
      default: cos_out = y_r[21:0];
    endcase
  end
  assign done = done_r;
endmodule

// File: rtl/frame_window_apply.sv
// Datapath: phase divide, one CORDIC pass (two for Blackman) for the cosine windows, a
//   coefficient divide for Bartlett and trapezoid, sample and gain multiplies, output load;
//   when N is 1 the block goes from the phase divide straight to the multiplies.
// Flow: a new sample is taken only in idle; pad zeros follow at one per cycle while the
//   output is not stalled, and a stalled result holds the datapath in the output state.
// Reset: synchronous, active low; registers to 255/0/1/65536, position 0.
// ----------------------------------------------------------------------------
// frame_window_apply
// Window coefficient generation and sample weighting, bit-serial datapath.
// ----------------------------------------------------------------------------
`include "frame_window_apply_defines.svh"
module frame_window_apply #(
  parameter int MAX_FRAME = fwa_pkg::MAX_FRAME_DEF,
  parameter int MAX_PAD   = fwa_pkg::MAX_PAD_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_windowed_sample,
  output logic               out_frame_end,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001, S_PDIV = 9'b000000010, S_COS1 = 9'b000000100,
    S_COS2 = 9'b000001000, S_VDIV = 9'b000010000, S_COEF = 9'b000100000,
    S_MUL1 = 9'b001000000, S_MUL2 = 9'b010000000, S_OUT  = 9'b100000000
  } st_t;

  localparam logic [9:0] NCAP  = 10'(((MAX_FRAME > 1024) ? 1024 : MAX_FRAME) - 1);
  localparam logic [5:0] PCAP  = 6'(MAX_PAD);

  logic [9:0]  ord_r;
  logic [5:0]  pad_r;
  logic [2:0]  win_r;
  logic [16:0] gain_r;
  logic [9:0]  pos_r;
  st_t         st_r;
  logic [5:0]  cnt_r;
  logic [5:0]  pleft_r;
  logic        last_r;
  logic [9:0]  i_r, m_r;
  logic [34:0] quo_r;
  logic [10:0] rem_r;
  logic [23:0] ph_r;
  logic signed [21:0] c1_r, c2_r;
  logic signed [17:0] w_r;
  logic signed [35:0] acc_r;
  logic signed [15:0] smp_r;
  logic signed [52:0] prod_r;
  logic signed [15:0] ores_r;
  logic        ofe_r, ov_r;
  logic        cstart;
  logic [23:0] cph;
  logic        cdone;
  logic signed [21:0] ccos;

  fwa_cordic u_cordic (.clk(clk), .rst_n(rst_n), .start(cstart), .phase(cph),
    .done(cdone), .cos_out(ccos));

  assign pready = 1'b1;
  always_comb begin
    case (paddr[3:2])
      fwa_pkg::REG_ORDER: prdata = {22'd0, ord_r};
      fwa_pkg::REG_PAD:   prdata = {26'd0, pad_r};
      fwa_pkg::REG_WIN:   prdata = {29'd0, win_r};
      default:            prdata = {15'd0, gain_r};
    endcase
  end

  logic [9:0] nm1;
  assign nm1 = (ord_r > NCAP) ? NCAP : ord_r;
  wire [10:0] n_w = {1'b0, m_r} + 11'd1;
  wire [10:0] hh  = (n_w + 11'd1) >> 1;
  wire [10:0] qq  = (n_w + 11'd2) >> 2;
  wire is_tri = (win_r == fwa_pkg::WIN_BARTLETT) || (win_r == fwa_pkg::WIN_TRAP);
  wire is_cos = (win_r == fwa_pkg::WIN_BLACKMAN) || (win_r == fwa_pkg::WIN_HAMMING) ||
                (win_r == fwa_pkg::WIN_HANN);
  wire [11:0] rsh = {rem_r, quo_r[34]};
  wire        rge = rsh >= {2'b0, m_r};

  assign in_stall = (st_r != S_IDLE);
  assign cph = (st_r == S_PDIV) ? {quo_r[22:0], rge} : {ph_r[22:0], 1'b0};
  assign cstart = ((st_r == S_PDIV) && (cnt_r == 6'd0) && is_cos) ||
                  ((st_r == S_COS1) && cdone && (win_r == fwa_pkg::WIN_BLACKMAN));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ord_r <= 10'd255; pad_r <= '0; win_r <= fwa_pkg::WIN_HAMMING; gain_r <= 17'd65536;
      pos_r <= '0; st_r <= S_IDLE; ov_r <= 1'b0; cnt_r <= '0; pleft_r <= '0;
    end else begin
      if (psel && penable && pwrite)
        case (paddr[3:2])
          fwa_pkg::REG_ORDER: ord_r <= pwdata[9:0];
          fwa_pkg::REG_PAD:   pad_r <= pwdata[5:0];
          fwa_pkg::REG_WIN:   win_r <= pwdata[2:0];
          default:            gain_r <= pwdata[16:0];
        endcase
      if ((st_r == S_OUT) && (!ov_r || !out_stall)) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: if (in_valid) begin
          smp_r <= in_sample; m_r <= nm1;
          last_r <= pos_r >= nm1;
          i_r <= (pos_r >= nm1) ? nm1 : pos_r;
          pos_r <= (pos_r >= nm1) ? 10'd0 : pos_r + 10'd1;
          quo_r <= {1'b0, ((pos_r >= nm1) ? nm1 : pos_r), 24'd0};
          rem_r <= '0; cnt_r <= 6'd34; st_r <= S_PDIV;
        end
        S_PDIV: begin
          if (m_r == 10'd0) begin
            w_r <= $signed(fwa_pkg::ONE_Q17); st_r <= S_MUL1; cnt_r <= 6'd17;
            acc_r <= '0;
          end else if (cnt_r != 6'd0) begin
            rem_r <= rge ? 11'(rsh - {2'b0, m_r}) : rsh[10:0];
            quo_r <= {quo_r[33:0], rge};
            cnt_r <= cnt_r - 6'd1;
          end else begin
            ph_r <= {quo_r[22:0], rge};
            if (is_cos) st_r <= S_COS1;
            else if (is_tri) begin
              quo_r <= (win_r == fwa_pkg::WIN_TRAP) ?
                       (({25'd0, i_r} << 19) + 35'(m_r >> 1)) :
                       (({25'd0, i_r} << 18) + 35'(m_r >> 1));
              rem_r <= '0; cnt_r <= 6'd34; st_r <= S_VDIV;
            end else begin
              w_r <= $signed(fwa_pkg::ONE_Q17); st_r <= S_MUL1; cnt_r <= 6'd17;
              acc_r <= '0;
            end
          end
        end
        S_COS1: if (cdone) begin
          c1_r <= ccos;
          st_r <= (win_r == fwa_pkg::WIN_BLACKMAN) ? S_COS2 : S_COEF;
        end
        S_COS2: if (cdone) begin c2_r <= ccos; st_r <= S_COEF; end
        S_VDIV: begin
          // long division of (i*2^s + m/2) by m, s = 18 or 19
          rem_r <= rge ? 11'(rsh - {2'b0, m_r}) : rsh[10:0];
          quo_r <= {quo_r[33:0], rge};
          if (cnt_r == 6'd0) begin
            acc_r <= 36'({quo_r[33:0], rge}); st_r <= S_COEF;
          end else cnt_r <= cnt_r - 6'd1;
        end
        S_COEF: begin
          logic signed [47:0] a;
          logic signed [47:0] r;
          case (win_r)
            fwa_pkg::WIN_BLACKMAN:
              a = 48'sd440402 * 48'sd1048576 - 48'(c1_r) * 48'sd524288 +
                  48'(c2_r) * 48'sd83886;
            fwa_pkg::WIN_HAMMING:
              a = 48'sd566231 * 48'sd1048576 - 48'(c1_r) * 48'sd482345;
            fwa_pkg::WIN_HANN:
              a = 48'sd549755813888 - 48'(c1_r) * 48'sd524288;
            default: a = '0;
          endcase
          r = (a + 48'sd4194304) >>> 23;
          if (win_r == fwa_pkg::WIN_BARTLETT)
            r = ({1'b0, i_r} < hh) ? 48'(acc_r) : 48'sd262144 - 48'(acc_r);
          else if (win_r == fwa_pkg::WIN_TRAP)
            r = ({1'b0, i_r} >= n_w - qq) ? 48'sd524288 - 48'(acc_r) :
                ({1'b0, i_r} < qq) ? 48'(acc_r) : 48'sd131072;
          if (r < 0) w_r <= '0;
          else if (r > 48'sd131072) w_r <= $signed(fwa_pkg::ONE_Q17);
          else w_r <= 18'(r);
          acc_r <= '0; cnt_r <= 6'd17; st_r <= S_MUL1;
        end
        S_MUL1: begin
          // shift-add: sample * w, one bit of w per cycle
          if (w_r[0]) acc_r <= acc_r + (36'(smp_r) <<< (6'd17 - cnt_r));
          w_r <= w_r >>> 1;
          if (cnt_r == 6'd0) begin
            cnt_r <= 6'd16; prod_r <= '0; st_r <= S_MUL2;
          end else cnt_r <= cnt_r - 6'd1;
        end
        S_MUL2: begin
          if (gain_r[5'(6'd16 - cnt_r)]) prod_r <= prod_r + (53'(acc_r) <<< (6'd16 - cnt_r));
          if (cnt_r == 6'd0) st_r <= S_OUT;
          else cnt_r <= cnt_r - 6'd1;
        end
        S_OUT: if (!ov_r || !out_stall) begin
          logic signed [52:0] y;
          y = (prod_r + 53'sd4294967296) >>> 33;
          if (pleft_r != 6'd0) begin
            ores_r <= '0; ofe_r <= (pleft_r == 6'd1); pleft_r <= pleft_r - 6'd1;
            if (pleft_r == 6'd1) st_r <= S_IDLE;
          end else begin
            ores_r <= (y > 53'sd32767) ? 16'sd32767 :
                      (y < -53'sd32768) ? -16'sd32768 : 16'(y);
            if (last_r && ((pad_r > PCAP) ? PCAP : pad_r) != 6'd0) begin
              ofe_r <= 1'b0; pleft_r <= (pad_r > PCAP) ? PCAP : pad_r;
            end else begin
              ofe_r <= last_r; st_r <= S_IDLE;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = ov_r;
  assign out_windowed_sample = ores_r;
  assign out_frame_end = ofe_r;

  `FWA_ASSERT_IMP(a_no_accept_busy, clk, rst_n, st_r != S_IDLE, in_stall)
  `FWA_ASSERT_NEXT(a_pad_zero, clk, rst_n,
    st_r == S_OUT && pleft_r != 6'd0 && (!ov_r || !out_stall), out_windowed_sample == 16'sd0)
  `FWA_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_windowed_sample))
endmodule
